### hdl/convex_support_hill_climb_defines.svh
// Assertion macros for the convex support hill climber.
// Taken in by the top level; expects i_clk and i_rst_n in scope.
`ifndef CONVEX_SUPPORT_HILL_CLIMB_DEFINES_SVH
`define CONVEX_SUPPORT_HILL_CLIMB_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define CSHC_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define CSHC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hdl/cshc_pkg.sv
// Shared sizes, types and codes for the convex support hill climber.
// No dependencies; imported by cshc_datapath, cshc_ctrl, the top level and the testbench files.
`default_nettype none

package cshc_pkg;

    localparam int MAX_VERTICES = 256;
    localparam int MAX_DEGREE   = 16;
    localparam int COORD_BITS   = 16;

    // Fixed field widths of the request and result items
    localparam int REQ_W  = 2;
    localparam int VIDX_W = 8;
    localparam int SLOT_W = 4;
    localparam int NB_W   = 8;
    localparam int CNT_W  = 5;

    // Derived storage widths
    localparam int VA_W   = $clog2(MAX_VERTICES);
    localparam int ADJ_AW = $clog2(MAX_VERTICES * MAX_DEGREE);
    localparam int DEG_W  = $clog2(MAX_DEGREE + 1);
    localparam int IDX_W  = DEG_W;
    localparam int PROD_W = 2 * COORD_BITS;
    localparam int DOT_W  = PROD_W + 2;

    // Request codes
    localparam logic [REQ_W-1:0] REQ_LOAD_VTX = 2'd0;
    localparam logic [REQ_W-1:0] REQ_LOAD_ADJ = 2'd1;
    localparam logic [REQ_W-1:0] REQ_QUERY    = 2'd2;

    typedef logic signed [COORD_BITS-1:0] t_coord;

    typedef struct packed {
        t_coord x;
        t_coord y;
        t_coord z;
    } t_pos;

    typedef enum logic [3:0] {
        S_IDLE,
        S_RD_CUR,
        S_CUR_MUL,
        S_CUR_SUM,
        S_SCAN,
        S_NB_CHK,
        S_NB_MUL,
        S_NB_CMP,
        S_DONE
    } t_state;

    // Controller to datapath commands
    typedef struct packed {
        logic wr_vtx;
        logic wr_adj;
        logic clear_cur;
        logic query_start;
        logic rd_cur;
        logic take_cur;
        logic set_h;
        logic rd_adj;
        logic rd_nb;
        logic next_idx;
        logic move;
        logic out_load;
    } t_dp_cmd;

    // Datapath to controller status
    typedef struct packed {
        logic idx_end;
        logic skip;
        logic better;
    } t_dp_sts;

endpackage

`default_nettype wire

### hdl/cshc_datapath.sv
// Datapath of the hill climber: vertex, degree and adjacency memories,
// dot-product unit, walk registers and result register. Uses cshc_pkg.
`default_nettype none

module cshc_datapath (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  cshc_pkg::t_dp_cmd         i_cmd,
    output cshc_pkg::t_dp_sts         o_sts,
    input  logic [cshc_pkg::VIDX_W-1:0] i_vertex_index,
    input  logic [cshc_pkg::SLOT_W-1:0] i_slot_index,
    input  logic [cshc_pkg::NB_W-1:0]   i_neighbor_vertex,
    input  logic [cshc_pkg::CNT_W-1:0]  i_neighbor_count,
    input  cshc_pkg::t_coord          i_coord_x,
    input  cshc_pkg::t_coord          i_coord_y,
    input  cshc_pkg::t_coord          i_coord_z,
    output logic [cshc_pkg::NB_W-1:0]   o_support_vertex,
    output cshc_pkg::t_coord          o_support_x,
    output cshc_pkg::t_coord          o_support_y,
    output cshc_pkg::t_coord          o_support_z
);
    import cshc_pkg::*;

    t_pos               r_vtx_mem [MAX_VERTICES];
    logic [DEG_W-1:0]   r_deg_mem [MAX_VERTICES];
    logic [NB_W-1:0]    r_adj_mem [MAX_VERTICES * MAX_DEGREE];

    t_pos               r_vtx_q;
    logic [DEG_W-1:0]   r_deg_q;
    logic [NB_W-1:0]    r_adj_q;

    t_pos               r_dir;
    t_pos               r_cur_pos;
    logic [VA_W-1:0]    r_cur;
    logic [VA_W-1:0]    r_last;
    logic               r_have_last;
    logic [IDX_W-1:0]   r_idx;
    logic signed [PROD_W-1:0] r_prod [3];
    logic signed [DOT_W-1:0]  r_h;

    logic               w_vi_ok;
    logic               w_slot_ok;
    logic [DEG_W-1:0]   w_deg;
    logic [VA_W-1:0]    w_wa;
    logic [ADJ_AW-1:0]  w_adj_wa;
    logic [ADJ_AW-1:0]  w_adj_ra;
    logic [VA_W-1:0]    w_vtx_ra;
    logic signed [DOT_W-1:0] w_dot;

    assign w_vi_ok   = int'(i_vertex_index) < MAX_VERTICES;
    assign w_slot_ok = int'(i_slot_index) < MAX_DEGREE;
    assign w_deg     = (int'(i_neighbor_count) > MAX_DEGREE) ? DEG_W'(MAX_DEGREE)
                                                             : DEG_W'(i_neighbor_count);
    assign w_wa      = VA_W'(i_vertex_index);
    assign w_adj_wa  = ADJ_AW'(i_vertex_index) * ADJ_AW'(MAX_DEGREE) + ADJ_AW'(i_slot_index);
    assign w_adj_ra  = ADJ_AW'(r_cur) * ADJ_AW'(MAX_DEGREE) + ADJ_AW'(r_idx);
    assign w_vtx_ra  = i_cmd.rd_nb ? VA_W'(r_adj_q) : r_cur;

    // Memory writes
    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_vtx && w_vi_ok) begin
            r_vtx_mem[w_wa] <= '{x: i_coord_x, y: i_coord_y, z: i_coord_z};
            r_deg_mem[w_wa] <= w_deg;
        end
        if (i_cmd.wr_adj && w_vi_ok && w_slot_ok) begin
            r_adj_mem[w_adj_wa] <= i_neighbor_vertex;
        end
    end

    // Registered memory reads
    always_ff @(posedge i_clk) begin
        if (i_cmd.rd_cur || i_cmd.rd_nb) begin
            r_vtx_q <= r_vtx_mem[w_vtx_ra];
        end
        if (i_cmd.rd_cur) begin
            r_deg_q <= r_deg_mem[r_cur];
        end
        if (i_cmd.rd_adj) begin
            r_adj_q <= r_adj_mem[w_adj_ra];
        end
    end

    // Products of the last read position with the direction
    always_ff @(posedge i_clk) begin
        r_prod[0] <= r_vtx_q.x * r_dir.x;
        r_prod[1] <= r_vtx_q.y * r_dir.y;
        r_prod[2] <= r_vtx_q.z * r_dir.z;
    end

    assign w_dot = DOT_W'(r_prod[0]) + DOT_W'(r_prod[1]) + DOT_W'(r_prod[2]);

    // Walk state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur       <= '0;
            r_have_last <= 1'b0;
        end else begin
            if (i_cmd.clear_cur) begin
                r_cur <= '0;
            end else if (i_cmd.move) begin
                r_cur <= VA_W'(r_adj_q);
            end
            if (i_cmd.query_start) begin
                r_have_last <= 1'b0;
            end else if (i_cmd.move) begin
                r_have_last <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.query_start) begin
            r_dir <= '{x: i_coord_x, y: i_coord_y, z: i_coord_z};
        end
        if (i_cmd.move) begin
            r_last <= r_cur;
        end
        if (i_cmd.take_cur) begin
            r_cur_pos <= r_vtx_q;
        end
        if (i_cmd.set_h) begin
            r_h   <= w_dot;
            r_idx <= '0;
        end else if (i_cmd.next_idx) begin
            r_idx <= r_idx + IDX_W'(1);
        end
        if (i_cmd.out_load) begin
            o_support_vertex <= NB_W'(r_cur);
            o_support_x      <= r_cur_pos.x;
            o_support_y      <= r_cur_pos.y;
            o_support_z      <= r_cur_pos.z;
        end
    end

    assign o_sts.idx_end = (r_idx == IDX_W'(r_deg_q));
    assign o_sts.skip    = (int'(r_adj_q) >= MAX_VERTICES)
                        || (r_have_last && (int'(r_adj_q) == int'(r_last)));
    assign o_sts.better  = (w_dot > r_h);

endmodule

`default_nettype wire

### hdl/cshc_ctrl.sv
// Controller of the hill climber: request decode, walk sequencing and the
// result valid flag. Uses cshc_pkg; drives cshc_datapath by command struct.
`default_nettype none

module cshc_ctrl (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    input  logic [cshc_pkg::REQ_W-1:0]  i_req_type,
    output logic                        o_stall,
    output logic                        o_valid,
    input  logic                        i_stall,
    output cshc_pkg::t_dp_cmd           o_cmd,
    input  cshc_pkg::t_dp_sts           i_sts
);
    import cshc_pkg::*;

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   n_out_valid;
    logic   w_out_free;

    assign w_out_free = !r_out_valid || !i_stall;
    assign o_stall    = (r_state != S_IDLE);
    assign o_valid    = r_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        n_out_valid = r_out_valid && i_stall;
        if (o_cmd.out_load) begin
            n_out_valid = 1'b1;
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_valid && (i_req_type == REQ_QUERY)) begin
                    n_state = S_RD_CUR;
                end
            end
            S_RD_CUR:  n_state = S_CUR_MUL;
            S_CUR_MUL: n_state = S_CUR_SUM;
            S_CUR_SUM: n_state = S_SCAN;
            S_SCAN: begin
                n_state = i_sts.idx_end ? S_DONE : S_NB_CHK;
            end
            S_NB_CHK: begin
                n_state = i_sts.skip ? S_SCAN : S_NB_MUL;
            end
            S_NB_MUL:  n_state = S_NB_CMP;
            S_NB_CMP: begin
                n_state = i_sts.better ? S_RD_CUR : S_SCAN;
            end
            S_DONE: begin
                if (w_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default:   n_state = S_IDLE;
        endcase
    end

    // Commands
    always_comb begin
        o_cmd = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    unique case (i_req_type)
                        REQ_LOAD_VTX: begin
                            o_cmd.wr_vtx    = 1'b1;
                            o_cmd.clear_cur = 1'b1;
                        end
                        REQ_LOAD_ADJ: begin
                            o_cmd.wr_adj    = 1'b1;
                            o_cmd.clear_cur = 1'b1;
                        end
                        REQ_QUERY: o_cmd.query_start = 1'b1;
                        default: ;
                    endcase
                end
            end
            S_RD_CUR:  o_cmd.rd_cur   = 1'b1;
            S_CUR_MUL: o_cmd.take_cur = 1'b1;
            S_CUR_SUM: o_cmd.set_h    = 1'b1;
            S_SCAN:    o_cmd.rd_adj   = !i_sts.idx_end;
            S_NB_CHK: begin
                o_cmd.next_idx = i_sts.skip;
                o_cmd.rd_nb    = !i_sts.skip;
            end
            S_NB_MUL: ;
            S_NB_CMP: begin
                o_cmd.move     = i_sts.better;
                o_cmd.next_idx = !i_sts.better;
            end
            S_DONE:    o_cmd.out_load = w_out_free;
            default: ;
        endcase
    end

endmodule

`default_nettype wire

### hdl/convex_support_hill_climb.sv
// Top level of the convex support hill climber: joins controller and datapath.
// Depends on cshc_pkg, cshc_ctrl, cshc_datapath and the assertion macro header.
//
//   channel   direction  handshake           payload
//   request   in         i_valid / o_stall   i_req_type .. i_coord_z
//   result    out        o_valid / i_stall   o_support_vertex .. o_support_z
//
// A load is written as soon as it is taken. A query fetches and scores the
// start vertex, then for each visited vertex scores its listed neighbors in
// turn, skipping the vertex just left; the single vertex-memory read port and
// the registered multiply before each compare set the pace of each step.
// Reset (synchronous, active low) clears the walk start vertex and the flags;
// the memories are not cleared. The result register lets a finished result
// wait under i_stall while the next request is taken.
`default_nettype none

module convex_support_hill_climb (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic [cshc_pkg::REQ_W-1:0]    i_req_type,
    input  logic [cshc_pkg::VIDX_W-1:0]   i_vertex_index,
    input  logic [cshc_pkg::SLOT_W-1:0]   i_slot_index,
    input  logic [cshc_pkg::NB_W-1:0]     i_neighbor_vertex,
    input  logic [cshc_pkg::CNT_W-1:0]    i_neighbor_count,
    input  cshc_pkg::t_coord              i_coord_x,
    input  cshc_pkg::t_coord              i_coord_y,
    input  cshc_pkg::t_coord              i_coord_z,
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic [cshc_pkg::NB_W-1:0]     o_support_vertex,
    output cshc_pkg::t_coord              o_support_x,
    output cshc_pkg::t_coord              o_support_y,
    output cshc_pkg::t_coord              o_support_z
);
    import cshc_pkg::*;

`include "convex_support_hill_climb_defines.svh"

    t_dp_cmd w_cmd;
    t_dp_sts w_sts;

    // Sequencing: request decode, walk steps, result valid
    cshc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .i_req_type (i_req_type),
        .o_stall    (o_stall),
        .o_valid    (o_valid),
        .i_stall    (i_stall),
        .o_cmd      (w_cmd),
        .i_sts      (w_sts)
    );

    // Storage, dot products and the result payload
    cshc_datapath u_datapath (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (w_cmd),
        .o_sts             (w_sts),
        .i_vertex_index    (i_vertex_index),
        .i_slot_index      (i_slot_index),
        .i_neighbor_vertex (i_neighbor_vertex),
        .i_neighbor_count  (i_neighbor_count),
        .i_coord_x         (i_coord_x),
        .i_coord_y         (i_coord_y),
        .i_coord_z         (i_coord_z),
        .o_support_vertex  (o_support_vertex),
        .o_support_x       (o_support_x),
        .o_support_y       (o_support_y),
        .o_support_z       (o_support_z)
    );

    // Never overwrite a result that is still waiting
    `CSHC_ASSERT_NOW(a_out_no_overwrite, w_cmd.out_load, !o_valid || !i_stall, "result overwritten while pending")
    // Hold off new requests once a query is taken
    `CSHC_ASSERT_NEXT(a_query_blocks, i_valid && !o_stall && i_req_type == REQ_QUERY, o_stall, "request taken during walk")
    // Advance only to a scored, improving neighbor
    `CSHC_ASSERT_NOW(a_move_improves, w_cmd.move, w_sts.better && !w_sts.skip, "move without improvement")
    // Read adjacency only inside the neighbor list
    `CSHC_ASSERT_NOW(a_adj_in_list, w_cmd.rd_adj, !w_sts.idx_end, "adjacency read past list end")

endmodule

`default_nettype wire

### tb/cshc_support_checker.sv
// Checker for the convex support hill climber: watches both channels, keeps a
// mirror of the mesh tables, predicts each support result and compares it.
// Depends on cshc_pkg for sizes, request codes and the coordinate types.

module cshc_support_checker (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_req_valid,
    input  logic                          i_req_stall,
    input  logic [cshc_pkg::REQ_W-1:0]    i_req_type,
    input  logic [cshc_pkg::VIDX_W-1:0]   i_vertex_index,
    input  logic [cshc_pkg::SLOT_W-1:0]   i_slot_index,
    input  logic [cshc_pkg::NB_W-1:0]     i_neighbor_vertex,
    input  logic [cshc_pkg::CNT_W-1:0]    i_neighbor_count,
    input  cshc_pkg::t_coord              i_coord_x,
    input  cshc_pkg::t_coord              i_coord_y,
    input  cshc_pkg::t_coord              i_coord_z,
    input  logic                          i_rsp_valid,
    input  logic                          i_rsp_stall,
    input  logic [cshc_pkg::NB_W-1:0]     i_support_vertex,
    input  cshc_pkg::t_coord              i_support_x,
    input  cshc_pkg::t_coord              i_support_y,
    input  cshc_pkg::t_coord              i_support_z,
    output int                            o_fail_count,
    output int                            o_pending_count
);
    timeunit 1ns;
    timeprecision 1ps;

    import cshc_pkg::*;

    typedef struct packed {
        logic [NB_W-1:0] vtx;
        t_pos            pos;
    } t_support;

    t_pos              vertex_pos     [MAX_VERTICES];
    logic [DEG_W-1:0]  vertex_degree  [MAX_VERTICES];
    logic [NB_W-1:0]   neighbor_table [MAX_VERTICES*MAX_DEGREE];
    int unsigned       warm_start;
    t_support          pending_supports [$];

    task automatic flag_mismatch(input string what);
        o_fail_count++;
        $display("[%0t] MISMATCH %s", $time, what);
    endtask

    // Exact dot product of a stored vertex with the query direction
    function automatic longint facing(input int unsigned v, input t_pos dir);
        t_pos p;
        p = vertex_pos[v];
        return longint'($signed(p.x)) * longint'($signed(dir.x))
             + longint'($signed(p.y)) * longint'($signed(dir.y))
             + longint'($signed(p.z)) * longint'($signed(dir.z));
    endfunction

    // Walk uphill from the warm-start vertex; take the first strictly better
    // neighbor, never step back to the vertex just left.
    task automatic climb_to_support(input t_pos dir);
        int unsigned here;
        int unsigned came_from;
        int unsigned span;
        int unsigned nb;
        int unsigned step_to;
        bit          have_came;
        bit          moved;
        longint      height;
        longint      trial;
        t_support    found;
        here      = (warm_start < MAX_VERTICES) ? warm_start : 0;
        came_from = 0;
        have_came = 1'b0;
        step_to   = 0;
        trial     = 0;
        height    = facing(here, dir);
        do begin
            moved = 1'b0;
            span  = vertex_degree[here];
            if (span > MAX_DEGREE) span = MAX_DEGREE;
            for (int i = 0; i < span && !moved; i++) begin
                nb = neighbor_table[here*MAX_DEGREE + i];
                if ((have_came && nb == came_from) || nb >= MAX_VERTICES) continue;
                trial = facing(nb, dir);
                if (trial > height) begin
                    step_to = nb;
                    moved   = 1'b1;
                end
            end
            if (moved) begin
                came_from = here;
                have_came = 1'b1;
                here      = step_to;
                height    = trial;
            end
        end while (moved);
        warm_start = here;
        found.vtx  = NB_W'(here);
        found.pos  = vertex_pos[here];
        pending_supports.insert(pending_supports.size(), found);
    endtask

    task automatic take_request();
        int unsigned v;
        int unsigned s;
        int unsigned cnt;
        t_pos        c;
        v   = i_vertex_index;
        s   = i_slot_index;
        cnt = i_neighbor_count;
        c   = '{i_coord_x, i_coord_y, i_coord_z};
        case (i_req_type)
            REQ_LOAD_VTX: begin
                if (v < MAX_VERTICES) begin
                    vertex_pos[v]    = c;
                    vertex_degree[v] = DEG_W'((cnt > MAX_DEGREE) ? MAX_DEGREE : cnt);
                end
                warm_start = 0;
            end
            REQ_LOAD_ADJ: begin
                if (v < MAX_VERTICES && s < MAX_DEGREE)
                    neighbor_table[v*MAX_DEGREE + s] = i_neighbor_vertex;
                warm_start = 0;
            end
            REQ_QUERY: climb_to_support(c);
            default: ;
        endcase
    endtask

    task automatic check_support();
        t_support want;
        if (pending_supports.size() == 0) begin
            flag_mismatch($sformatf("unexpected result: vertex %0d", i_support_vertex));
            return;
        end
        want = pending_supports.pop_front();
        if (i_support_vertex !== want.vtx)
            flag_mismatch($sformatf("support_vertex got %0d want %0d",
                                    i_support_vertex, want.vtx));
        if (i_support_x !== want.pos.x)
            flag_mismatch($sformatf("support_x got %0d want %0d (vertex %0d)",
                                    $signed(i_support_x), $signed(want.pos.x), want.vtx));
        if (i_support_y !== want.pos.y)
            flag_mismatch($sformatf("support_y got %0d want %0d (vertex %0d)",
                                    $signed(i_support_y), $signed(want.pos.y), want.vtx));
        if (i_support_z !== want.pos.z)
            flag_mismatch($sformatf("support_z got %0d want %0d (vertex %0d)",
                                    $signed(i_support_z), $signed(want.pos.z), want.vtx));
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            warm_start = 0;
            pending_supports.delete();
        end else begin
            if (i_rsp_valid && !i_rsp_stall) check_support();
            if (i_req_valid && !i_req_stall) take_request();
        end
        o_pending_count = pending_supports.size();
    end

endmodule

### tb/testbench.sv
// Top of the convex support hill climber testbench: clock, reset, request
// stimulus, result back-pressure and the verdict.
// Depends on cshc_pkg, convex_support_hill_climb and cshc_support_checker.

module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import cshc_pkg::*;

    // Request count that ends the random part (ignored requests not counted)
    localparam int REQUEST_TARGET = 1400;
    // Generous ceiling: long walks on the chain meshes, long stalls on both sides
    localparam int CYCLE_LIMIT    = 3_000_000;
    // Loads finish once taken, so a short tail covers anything still in flight
    localparam int DRAIN_CYCLES   = 200;
    // The one request code the block ignores
    localparam logic [REQ_W-1:0] REQ_RESERVED = 2'd3;

    localparam t_coord COORD_MAX = {1'b0, {(COORD_BITS-1){1'b1}}};
    localparam t_coord COORD_MIN = {1'b1, {(COORD_BITS-1){1'b0}}};
    localparam t_coord COORD_ONE = t_coord'(1);
    localparam t_coord COORD_NIL = '0;

    typedef struct {
        logic [REQ_W-1:0]  kind;
        logic [VIDX_W-1:0] vtx;
        logic [SLOT_W-1:0] slot;
        logic [NB_W-1:0]   nb;
        logic [CNT_W-1:0]  cnt;
        t_pos              p;
    } t_request;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_valid = 1'b0;
    logic               o_stall;
    logic [REQ_W-1:0]   i_req_type = '0;
    logic [VIDX_W-1:0]  i_vertex_index = '0;
    logic [SLOT_W-1:0]  i_slot_index = '0;
    logic [NB_W-1:0]    i_neighbor_vertex = '0;
    logic [CNT_W-1:0]   i_neighbor_count = '0;
    t_coord             i_coord_x = '0;
    t_coord             i_coord_y = '0;
    t_coord             i_coord_z = '0;
    logic               o_valid;
    logic               i_stall = 1'b0;
    logic [NB_W-1:0]    o_support_vertex;
    t_coord             o_support_x;
    t_coord             o_support_y;
    t_coord             o_support_z;

    int                 fail_count;
    int                 pending_count;
    int unsigned        cycle_count = 0;

    // What the block has been told so far; used to keep every query inside
    // the part of the mesh that has actually been written.
    bit                 vtx_loaded    [MAX_VERTICES];
    int unsigned        loaded_degree [MAX_VERTICES];
    bit                 slot_loaded   [MAX_VERTICES*MAX_DEGREE];
    int unsigned        slot_target   [MAX_VERTICES*MAX_DEGREE];
    int unsigned        mesh_ids [$];
    int                 requests_sent = 0;
    int unsigned        burst_left = 0;

    convex_support_hill_climb dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_valid           (i_valid),
        .o_stall           (o_stall),
        .i_req_type        (i_req_type),
        .i_vertex_index    (i_vertex_index),
        .i_slot_index      (i_slot_index),
        .i_neighbor_vertex (i_neighbor_vertex),
        .i_neighbor_count  (i_neighbor_count),
        .i_coord_x         (i_coord_x),
        .i_coord_y         (i_coord_y),
        .i_coord_z         (i_coord_z),
        .o_valid           (o_valid),
        .i_stall           (i_stall),
        .o_support_vertex  (o_support_vertex),
        .o_support_x       (o_support_x),
        .o_support_y       (o_support_y),
        .o_support_z       (o_support_z)
    );

    cshc_support_checker support_checker (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_req_valid       (i_valid),
        .i_req_stall       (o_stall),
        .i_req_type        (i_req_type),
        .i_vertex_index    (i_vertex_index),
        .i_slot_index      (i_slot_index),
        .i_neighbor_vertex (i_neighbor_vertex),
        .i_neighbor_count  (i_neighbor_count),
        .i_coord_x         (i_coord_x),
        .i_coord_y         (i_coord_y),
        .i_coord_z         (i_coord_z),
        .i_rsp_valid       (o_valid),
        .i_rsp_stall       (i_stall),
        .i_support_vertex  (o_support_vertex),
        .i_support_x       (o_support_x),
        .i_support_y       (o_support_y),
        .i_support_z       (o_support_z),
        .o_fail_count      (fail_count),
        .o_pending_count   (pending_count)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    always @(posedge i_clk) cycle_count <= cycle_count + 1;

    // Watchdog: a hung block or a lost result ends here.
    initial begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("Test completed with failures");
        $finish;
    end

    // ------------------------------------------------------------------
    // Random field helpers
    // ------------------------------------------------------------------

    // Bias toward the extremes and toward small values so that ties,
    // zero directions and the largest products all come up often.
    function automatic t_coord rand_coord();
        case ($urandom_range(0, 9))
            0:       return COORD_MAX;
            1:       return COORD_MIN;
            2:       return COORD_NIL;
            3, 4, 5: return t_coord'($urandom_range(0, 400)) - t_coord'(200);
            default: return t_coord'($urandom);
        endcase
    endfunction

    function automatic t_pos rand_pos();
        t_pos p;
        p.x = rand_coord();
        p.y = rand_coord();
        p.z = rand_coord();
        return p;
    endfunction

    // Mostly ordinary degrees; now and then a full list, sometimes with a
    // count above the list size that the block has to clamp.
    function automatic int unsigned pick_count(input int unsigned top);
        if ($urandom_range(0, 99) < 6)
            return $urandom_range(MAX_DEGREE, (1 << CNT_W) - 1);
        return $urandom_range(0, top);
    endfunction

    function automatic int unsigned pick_member();
        return mesh_ids[$urandom_range(0, mesh_ids.size() - 1)];
    endfunction

    // Fill every field, used or not, so all payload bits toggle.
    function automatic t_request random_fields();
        t_request r;
        r.kind = REQ_RESERVED;
        r.vtx  = VIDX_W'($urandom);
        r.slot = SLOT_W'($urandom);
        r.nb   = NB_W'($urandom);
        r.cnt  = CNT_W'($urandom);
        r.p    = rand_pos();
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Request channel
    // ------------------------------------------------------------------

    // Drive one request at the falling edge, hold it until the block takes
    // it, then record what it wrote into the mesh bookkeeping.
    task automatic send_request(input t_request r);
        int unsigned gap;
        int          pick;
        if (burst_left > 0) begin
            gap = 0;
            burst_left--;
        end else begin
            pick = $urandom_range(0, 99);
            if (pick < 60)      gap = 0;
            else if (pick < 90) gap = $urandom_range(1, 3);
            else if (pick < 97) gap = $urandom_range(4, 12);
            else                gap = $urandom_range(20, 60);
            // Occasionally switch to a back-to-back stretch
            if ($urandom_range(0, 99) < 3) burst_left = $urandom_range(30, 120);
        end
        @(negedge i_clk);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_valid           <= 1'b1;
        i_req_type        <= r.kind;
        i_vertex_index    <= r.vtx;
        i_slot_index      <= r.slot;
        i_neighbor_vertex <= r.nb;
        i_neighbor_count  <= r.cnt;
        i_coord_x         <= r.p.x;
        i_coord_y         <= r.p.y;
        i_coord_z         <= r.p.z;
        do @(posedge i_clk); while (o_stall);
        case (r.kind)
            REQ_LOAD_VTX: begin
                vtx_loaded[r.vtx]    = 1'b1;
                loaded_degree[r.vtx] = (r.cnt > MAX_DEGREE) ? MAX_DEGREE : r.cnt;
            end
            REQ_LOAD_ADJ: begin
                slot_loaded[r.vtx*MAX_DEGREE + r.slot] = 1'b1;
                slot_target[r.vtx*MAX_DEGREE + r.slot] = r.nb;
            end
            default: ;
        endcase
        if (r.kind != REQ_RESERVED) requests_sent++;
    endtask

    task automatic load_vertex(input int unsigned v, input t_pos p, input int unsigned cnt);
        t_request r;
        r      = random_fields();
        r.kind = REQ_LOAD_VTX;
        r.vtx  = VIDX_W'(v);
        r.cnt  = CNT_W'(cnt);
        r.p    = p;
        send_request(r);
    endtask

    task automatic load_slot(input int unsigned v, input int unsigned s, input int unsigned nb);
        t_request r;
        r      = random_fields();
        r.kind = REQ_LOAD_ADJ;
        r.vtx  = VIDX_W'(v);
        r.slot = SLOT_W'(s);
        r.nb   = NB_W'(nb);
        send_request(r);
    endtask

    task automatic ask_support(input t_pos dir);
        t_request r;
        r      = random_fields();
        r.kind = REQ_QUERY;
        r.p    = dir;
        send_request(r);
    endtask

    // ------------------------------------------------------------------
    // Mesh bookkeeping
    // ------------------------------------------------------------------

    // Search the graph reachable from vertex 0 (every walk starts there or at
    // a vertex reached from there) for a vertex or a listed slot that was
    // never written. s < 0 means the vertex itself is missing.
    function automatic bit find_hole(output int unsigned v, output int s);
        bit          seen [MAX_VERTICES];
        int unsigned frontier [$];
        int unsigned here;
        int unsigned nb;
        seen = '{default: 1'b0};
        v = 0;
        s = 0;
        frontier.insert(frontier.size(), 0);
        seen[0] = 1'b1;
        while (frontier.size() > 0) begin
            here = frontier.pop_front();
            if (!vtx_loaded[here]) begin
                v = here;
                s = -1;
                return 1'b1;
            end
            for (int i = 0; i < loaded_degree[here]; i++) begin
                if (!slot_loaded[here*MAX_DEGREE + i]) begin
                    v = here;
                    s = i;
                    return 1'b1;
                end
                nb = slot_target[here*MAX_DEGREE + i];
                if (nb < MAX_VERTICES && !seen[nb]) begin
                    seen[nb] = 1'b1;
                    frontier.insert(frontier.size(), nb);
                end
            end
        end
        return 1'b0;
    endfunction

    // Patch holes with loads until any query is safe again.
    task automatic repair_mesh();
        int unsigned v;
        int          s;
        while (find_hole(v, s)) begin
            if (s < 0) load_vertex(v, rand_pos(), pick_count(4));
            else       load_slot(v, s, pick_member());
        end
    endtask

    // Load a fresh mesh that contains vertex 0. A chain lays the vertices out
    // along x and links each to its one or two chain neighbors, so a query walks far; the
    // other shape is a random graph.
    task automatic build_mesh(input int size, input bit chain, input int unsigned top_deg);
        bit          used [MAX_VERTICES];
        int unsigned v;
        int unsigned nb;
        bit          flip;
        t_pos        p;
        used = '{default: 1'b0};
        used[0] = 1'b1;
        mesh_ids.delete();
        while (mesh_ids.size() < size - 1) begin
            v = $urandom_range(1, MAX_VERTICES - 1);
            if (!used[v]) begin
                used[v] = 1'b1;
                mesh_ids.insert(mesh_ids.size(), v);
            end
        end
        mesh_ids.insert($urandom_range(0, size - 1), 0);
        for (int k = 0; k < size; k++) begin
            if (chain) begin
                p.x = t_coord'(k * (60000 / size) - 30000);
                p.y = t_coord'($urandom_range(0, 200)) - t_coord'(100);
                p.z = t_coord'($urandom_range(0, 200)) - t_coord'(100);
                load_vertex(mesh_ids[k], p, (k == 0 || k == size - 1) ? 1 : 2);
            end else begin
                load_vertex(mesh_ids[k], rand_pos(), pick_count(top_deg));
            end
        end
        for (int k = 0; k < size; k++) begin
            v    = mesh_ids[k];
            flip = $urandom_range(0, 1);
            for (int j = 0; j < loaded_degree[v]; j++) begin
                if (!chain)                  nb = pick_member();
                else if (k == 0)             nb = mesh_ids[1];
                else if (k == size - 1)      nb = mesh_ids[size - 2];
                else if ((j == 0) ^ flip)    nb = mesh_ids[k - 1];
                else                         nb = mesh_ids[k + 1];
                load_slot(v, j, nb);
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Result back-pressure
    // ------------------------------------------------------------------

    // Random stall runs, mostly short, a few long, plus stall-free stretches.
    // Twice hold the result channel for a long while so the block fills up
    // and has to stall its request side while requests keep coming.
    initial begin
        int unsigned run_left;
        int unsigned hold_left;
        int unsigned rx_cycle;
        int          pick;
        run_left  = 0;
        hold_left = 0;
        rx_cycle  = 0;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            rx_cycle++;
            if (rx_cycle == 3000 || rx_cycle == 30000) hold_left = 800;
            if (hold_left > 0) begin
                hold_left--;
                i_stall <= 1'b1;
            end else if (run_left > 0) begin
                run_left--;
            end else begin
                pick = $urandom_range(0, 99);
                if (pick < 55) begin
                    i_stall  <= 1'b0;
                    run_left  = $urandom_range(0, 20);
                end else if (pick < 88) begin
                    i_stall  <= 1'b1;
                    run_left  = $urandom_range(0, 2);
                end else if (pick < 97) begin
                    i_stall  <= 1'b1;
                    run_left  = $urandom_range(5, 30);
                end else begin
                    i_stall  <= 1'b0;
                    run_left  = $urandom_range(60, 200);
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus and verdict
    // ------------------------------------------------------------------

    initial begin
        t_request    r;
        int unsigned v;
        int          pick;
        int          round;

        // Hold reset from the start, release it at a falling edge
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed mesh: vertex 0 at the origin linked to a far corner (255),
        // the opposite corner (128) and a twin of the origin (1).
        mesh_ids = '{0, 128, 1, 255};
        load_vertex(0,   '{COORD_NIL, COORD_NIL, COORD_NIL}, 3);
        load_vertex(255, '{COORD_MAX, COORD_MAX, COORD_MAX}, 1);
        load_vertex(128, '{COORD_MIN, COORD_MIN, COORD_MIN}, 1);
        load_vertex(1,   '{COORD_NIL, COORD_NIL, COORD_NIL}, 0);
        load_slot(0, 0, 128);
        load_slot(0, 1, 1);
        load_slot(0, 2, 255);
        load_slot(255, 0, 0);
        load_slot(255, MAX_DEGREE - 1, 0);   // top slot, outside the listed range
        load_slot(128, 0, 0);
        // Reserved request code: must be dropped without a result
        r = random_fields();
        send_request(r);
        // Tie with vertex 1 must not move; vertex 255 wins; back-edge skipped
        ask_support('{COORD_ONE, COORD_ONE, COORD_ONE});
        // Zero direction: every score ties, stay at the warm start
        ask_support('{COORD_NIL, COORD_NIL, COORD_NIL});
        // Largest magnitudes: walk 255 -> 0 -> 128
        ask_support('{COORD_MIN, COORD_MIN, COORD_MIN});
        ask_support('{COORD_MAX, COORD_MIN, COORD_ONE});
        // A load sends the walk back to vertex 0 before the next query
        load_vertex(1, '{COORD_MAX, COORD_NIL, COORD_NIL}, 0);
        ask_support('{COORD_ONE, COORD_NIL, COORD_NIL});
        ask_support(rand_pos());

        // Random part: build a mesh, then mostly queries with random
        // directions, mixed with reloads, slot rewrites and stray requests.
        round = 0;
        while (requests_sent < REQUEST_TARGET) begin
            if (round == 2) build_mesh(64, 1'b0, 3);
            else            build_mesh($urandom_range(4, 16), $urandom_range(0, 2) == 0, 6);
            repair_mesh();
            repeat ($urandom_range(20, 60)) begin
                pick = $urandom_range(0, 99);
                if (pick < 78) begin
                    ask_support(rand_pos());
                end else if (pick < 87) begin
                    v = pick_member();
                    load_vertex(v, rand_pos(),
                                ($urandom_range(0, 3) == 0) ? pick_count(6) : loaded_degree[v]);
                end else if (pick < 95) begin
                    load_slot(pick_member(), $urandom_range(0, MAX_DEGREE - 1), pick_member());
                end else if (pick < 98) begin
                    r = random_fields();
                    send_request(r);
                end else begin
                    // Stray load anywhere, any count; repair covers a hit on the mesh
                    load_vertex($urandom_range(0, MAX_VERTICES - 1), rand_pos(),
                                $urandom_range(0, (1 << CNT_W) - 1));
                end
                repair_mesh();
            end
            round++;
        end

        @(negedge i_clk);
        i_valid <= 1'b0;

        // Drain: wait for every predicted result, then let loads settle
        while (pending_count != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);

        if (fail_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

### convex_support_hill_climb.f
+incdir+hdl
hdl/cshc_pkg.sv
hdl/cshc_datapath.sv
hdl/cshc_ctrl.sv
hdl/convex_support_hill_climb.sv
tb/cshc_support_checker.sv
tb/testbench.sv
